FILE: design/vfrq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfrq_pkg: shared types and constants for the frame ring queue
// Status and request codes, sequencer phases and the config bundle.
// ---------------------------------------------------------------------------
package vfrq_pkg;

  localparam int OFFSET_W = 11;
  localparam int WORD_W   = 32;
  localparam int SIZE_W   = 8;
  localparam int WIDX_W   = 8;
  localparam int FOFF_W   = 10;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int QB_MIN   = 16;
  localparam int QB_MAX   = 1024;

  // Register word index, taken from paddr[2]
  localparam logic REG_QUEUE_BYTES = 1'b0;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_SHIFT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL_WRAP  = 3'd1,
    ST_FULL_FRONT = 3'd2,
    ST_ZERO_SIZE  = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR,
    PH_EXEC
  } phase_t;

  typedef struct packed {
    logic                clear;
    logic [OFFSET_W-1:0] qb_next;
    logic [OFFSET_W-1:0] queue_bytes;
  } cfg_t;

  // Largest usable queue size for a given memory depth
  function automatic logic [OFFSET_W-1:0] qb_limit(input int words);
    if (words * 4 < QB_MAX) begin
      return OFFSET_W'(words * 4);
    end
    return OFFSET_W'(QB_MAX);
  endfunction

endpackage

FILE: design/vfrq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfrq_if: request and response channels of the frame ring queue
// Valid/ready channels; a request moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface vfrq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] data_word;
  logic        first_word;
  logic [7:0]  word_index;

  modport source (output valid, kind, data_word, first_word, word_index, input ready);
  modport sink   (input valid, kind, data_word, first_word, word_index, output ready);
endinterface

interface vfrq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] read_word;
  logic        is_empty;
  logic [9:0]  frame_offset;

  modport source (output valid, status, read_word, is_empty, frame_offset, input ready);
  modport sink   (input valid, status, read_word, is_empty, frame_offset, output ready);
endinterface

FILE: design/vfrq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfrq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ---------------------------------------------------------------------------
module vfrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/vfrq_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfrq_cfg: APB register file of the frame ring queue
// Holds queue_bytes, clamps written values and flags a queue clear.
// ---------------------------------------------------------------------------
module vfrq_cfg #(
  parameter int MEMORY_WORDS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vfrq_pkg::PADDR_W-1:0]    paddr,
  input  logic [vfrq_pkg::PDATA_W-1:0]    pwdata,
  output logic [vfrq_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output vfrq_pkg::cfg_t                  cfg
);
  import vfrq_pkg::*;

  localparam logic [OFFSET_W-1:0] QB_LIM = qb_limit(MEMORY_WORDS);

  logic [OFFSET_W-1:0] queue_bytes;
  logic [OFFSET_W-1:0] qb_round;
  logic [OFFSET_W-1:0] qb_clamped;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_BYTES);

  // Round down to a word and clamp to the usable range
  always_comb begin
    qb_round = {pwdata[OFFSET_W-1:2], 2'b00};
    if (qb_round < OFFSET_W'(QB_MIN)) begin
      qb_clamped = OFFSET_W'(QB_MIN);
    end else if (qb_round > QB_LIM) begin
      qb_clamped = QB_LIM;
    end else begin
      qb_clamped = qb_round;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_bytes <= QB_LIM;
    end else if (wr_en) begin
      queue_bytes <= qb_clamped;
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_QUEUE_BYTES) begin
      prdata = PDATA_W'(queue_bytes);
    end else begin
      prdata = '0;
    end
  end

  assign cfg.clear       = wr_en;
  assign cfg.qb_next     = qb_clamped;
  assign cfg.queue_bytes = queue_bytes;

endmodule

FILE: design/variable_frame_ring_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// variable_frame_ring_queue: ring queue of whole variable-length frames
// Frames stay contiguous in a word RAM; a frame that does not fit at the
// back wraps to offset 0 when the front leaves room.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one request: push a frame word, read a word of the front
//   frame, or drop the front frame. res returns one response per request
//   with status, read word, empty flag and frame offset.
//   The APB port holds queue_bytes; writing it empties the queue.
// Timing:
//   A request passes through an address cycle that launches the registered
//   RAM read, then an execute cycle that forms the response and updates the
//   offsets. The response register loads at the end of the execute cycle, and
//   requests are handled one at a time, paced by the registered RAM read.
//   A new request is taken in the cycle the previous one completes.
// Stall:
//   While res is held, one more request is taken and waits in its execute
//   cycle until the response register frees up.
// Reset:
//   Synchronous rst empties the queue, clears res.valid and idles the sequencer;
//   RAM contents are not cleared.
// ---------------------------------------------------------------------------
module variable_frame_ring_queue #(
  parameter int MEMORY_WORDS = 256,
  parameter int HEADER_BYTES = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  vfrq_in_if.sink                      cmd,
  vfrq_out_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vfrq_pkg::PADDR_W-1:0] paddr,
  input  logic [vfrq_pkg::PDATA_W-1:0] pwdata,
  output logic [vfrq_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import vfrq_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam logic [OFFSET_W-1:0] QB_LIM = qb_limit(MEMORY_WORDS);

  cfg_t cfg;

  phase_t state, state_next;
  logic   out_free, done, ram_re;

  // Request register
  logic [1:0]        it_kind;
  logic [WORD_W-1:0] it_data;
  logic              it_first;
  logic [WIDX_W-1:0] it_widx;

  // Queue state
  logic [OFFSET_W-1:0] front_offset, front_offset_next;
  logic [OFFSET_W-1:0] back_offset, back_offset_next;
  logic [OFFSET_W-1:0] wrap_mark, wrap_mark_next;
  logic [OFFSET_W-1:0] fill_pointer, fill_pointer_next;
  logic                push_accepted, push_accepted_next;

  // Read addressing
  logic [OFFSET_W-1:0] base;
  logic [OFFSET_W:0]   rd_addr;
  logic                rd_oob;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   load_data;

  // Execute datapath
  logic [OFFSET_W-1:0] push_fsz, shift_fsz;
  logic [OFFSET_W:0]   back_sum;
  logic [OFFSET_W:0]   fill_sum;
  logic [OFFSET_W-1:0] start;
  status_t             st;
  logic [WORD_W-1:0]   rword;
  logic [OFFSET_W-1:0] foff;
  logic                wr_req, ram_we;
  logic [OFFSET_W-1:0] wr_byte;

  function automatic logic [OFFSET_W-1:0] pad_size(input logic [SIZE_W-1:0] sz);
    logic [OFFSET_W-1:0] sum;
    sum = OFFSET_W'(sz) + OFFSET_W'(HEADER_BYTES + 3);
    return {sum[OFFSET_W-1:2], 2'b00};
  endfunction

  vfrq_cfg #(
    .MEMORY_WORDS(MEMORY_WORDS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !res.valid || res.ready;

  // Sequencer: next phase
  always_comb begin
    state_next = state;
    case (state)
      PH_IDLE: begin
        if (cmd.valid) state_next = PH_ADDR;
      end
      PH_ADDR: begin
        state_next = PH_EXEC;
      end
      PH_EXEC: begin
        if (out_free) state_next = cmd.valid ? PH_ADDR : PH_IDLE;
      end
      default: begin
        state_next = PH_IDLE;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    cmd.ready = 1'b0;
    done      = 1'b0;
    ram_re    = 1'b0;
    case (state)
      PH_IDLE: begin
        cmd.ready = 1'b1;
      end
      PH_ADDR: begin
        ram_re = 1'b1;
      end
      PH_EXEC: begin
        done      = out_free;
        cmd.ready = out_free;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  // Front frame base and word address; beyond queue_bytes reads as zero
  always_comb begin
    base = (front_offset >= wrap_mark) ? '0 : front_offset;
    if (it_kind == KIND_READ) begin
      rd_addr = (OFFSET_W + 1)'(base) + (OFFSET_W + 1)'({it_widx, 2'b00});
    end else begin
      rd_addr = (OFFSET_W + 1)'(base);
    end
    rd_oob    = rd_addr >= (OFFSET_W + 1)'(cfg.queue_bytes);
    load_data = rd_oob ? '0 : ram_rdata;
  end

  vfrq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEMORY_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(wr_byte[OFFSET_W-1:2])),
    .wdata (it_data),
    .re    (ram_re),
    .raddr (AW'(rd_addr[OFFSET_W:2])),
    .rdata (ram_rdata)
  );

  // Execute: allocate, fill, read or drop
  always_comb begin
    front_offset_next  = front_offset;
    back_offset_next   = back_offset;
    wrap_mark_next     = wrap_mark;
    fill_pointer_next  = fill_pointer;
    push_accepted_next = push_accepted;
    st       = ST_OK;
    rword    = '0;
    foff     = '0;
    wr_req   = 1'b0;
    wr_byte  = '0;
    start    = '0;
    push_fsz  = pad_size(it_data[23:16]);
    shift_fsz = pad_size(load_data[23:16]);
    back_sum  = (OFFSET_W + 1)'(back_offset) + (OFFSET_W + 1)'(push_fsz);
    fill_sum  = (OFFSET_W + 1)'(fill_pointer) + (OFFSET_W + 1)'(3'd4);

    if (it_kind == KIND_PUSH && it_first) begin
      push_accepted_next = 1'b0;
      if (it_data[23:16] == '0) begin
        st = ST_ZERO_SIZE;
      end else if (front_offset <= back_offset) begin
        if (back_sum <= (OFFSET_W + 1)'(cfg.queue_bytes)) begin
          start            = back_offset;
          back_offset_next = back_sum[OFFSET_W-1:0];
        end else if (front_offset > push_fsz) begin
          wrap_mark_next   = back_offset;
          start            = '0;
          back_offset_next = push_fsz;
        end else begin
          st = ST_FULL_WRAP;
        end
      end else begin
        if (back_sum < (OFFSET_W + 1)'(front_offset)) begin
          start            = back_offset;
          back_offset_next = back_sum[OFFSET_W-1:0];
        end else begin
          st = ST_FULL_FRONT;
        end
      end
      if (st == ST_OK) begin
        wr_req             = 1'b1;
        wr_byte            = start;
        fill_pointer_next  = start + OFFSET_W'(4);
        push_accepted_next = fill_pointer_next < back_offset_next;
        foff               = start;
      end
    end else if (it_kind == KIND_PUSH) begin
      if (push_accepted && fill_pointer < back_offset) begin
        wr_req            = 1'b1;
        wr_byte           = fill_pointer;
        fill_pointer_next = fill_sum[OFFSET_W-1:0];
        if (fill_sum >= (OFFSET_W + 1)'(back_offset)) push_accepted_next = 1'b0;
      end else begin
        push_accepted_next = 1'b0;
      end
    end else if (it_kind == KIND_READ || it_kind == KIND_SHIFT) begin
      if (front_offset == back_offset) begin
        st = ST_EMPTY;
      end else if (it_kind == KIND_READ) begin
        rword = load_data;
        foff  = base;
      end else begin
        if (front_offset >= wrap_mark) begin
          front_offset_next = shift_fsz;
          wrap_mark_next    = cfg.queue_bytes;
        end else begin
          front_offset_next = front_offset + shift_fsz;
        end
        foff = base;
      end
    end

    ram_we = done && wr_req && (32'(wr_byte[OFFSET_W-1:2]) < MEMORY_WORDS);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= PH_IDLE;
      res.valid     <= 1'b0;
      front_offset  <= '0;
      back_offset   <= '0;
      wrap_mark     <= QB_LIM;
      fill_pointer  <= '0;
      push_accepted <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (cfg.clear) begin
        front_offset  <= '0;
        back_offset   <= '0;
        wrap_mark     <= cfg.qb_next;
        fill_pointer  <= '0;
        push_accepted <= 1'b0;
      end else if (done) begin
        front_offset  <= front_offset_next;
        back_offset   <= back_offset_next;
        wrap_mark     <= wrap_mark_next;
        fill_pointer  <= fill_pointer_next;
        push_accepted <= push_accepted_next;
      end
    end
  end

  // Request and response payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      it_kind  <= cmd.kind;
      it_data  <= cmd.data_word;
      it_first <= cmd.first_word;
      it_widx  <= cmd.word_index;
    end
    if (done) begin
      res.status       <= st;
      res.read_word    <= rword;
      res.is_empty     <= (front_offset_next == back_offset_next);
      res.frame_offset <= foff[FOFF_W-1:0];
    end
  end

  // Checks
  a_fill_inside: assert property (@(posedge clk) disable iff (rst)
    push_accepted |-> (fill_pointer < back_offset))
    else $error("fill pointer outside the frame being filled");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == PH_EXEC))
    else $error("RAM write outside the execute phase");

  a_addr_then_exec: assert property (@(posedge clk) disable iff (rst)
    (state == PH_ADDR) |=> (state == PH_EXEC))
    else $error("address phase not followed by execute phase");

  a_done_resp: assert property (@(posedge clk) disable iff (rst)
    done |=> res.valid)
    else $error("completed request left no response");

endmodule

FILE: sim/vfrq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfrq_checker: response predictor and scoreboard for the frame ring queue
// Watches the request, response and register channels, keeps its own image
// of the queue offsets and frame memory, and compares every response in order.
// ---------------------------------------------------------------------------
module vfrq_checker
  import vfrq_pkg::*;
#(
  parameter int MEM_WORDS = 256,
  parameter int HDR_BYTES = 12
) (
  input  logic               clk,
  input  logic               rst,
  vfrq_in_if                 req,
  vfrq_out_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 left_count
);

  typedef struct packed {
    status_t     status;
    logic [31:0] word;
    logic        empty;
    logic [9:0]  offset;
  } ring_resp_t;

  ring_resp_t          expected_resps[$];
  ring_resp_t          head_resp;
  logic [31:0]         ram_img [MEM_WORDS];
  logic [OFFSET_W-1:0] q_bytes;
  logic [OFFSET_W-1:0] head_off;
  logic [OFFSET_W-1:0] tail_off;
  logic [OFFSET_W-1:0] wrap_off;
  logic [OFFSET_W-1:0] fill_off;
  logic                fill_open;

  // Round down to a word and hold within the usable range
  function automatic logic [OFFSET_W-1:0] clamp_queue_bytes(input logic [31:0] v);
    logic [OFFSET_W-1:0] b;
    logic [OFFSET_W-1:0] lim;
    lim = (MEM_WORDS * 4 < QB_MAX) ? OFFSET_W'(MEM_WORDS * 4) : OFFSET_W'(QB_MAX);
    b = v[OFFSET_W-1:0] & ~OFFSET_W'(3);
    if (b < OFFSET_W'(QB_MIN)) b = OFFSET_W'(QB_MIN);
    if (b > lim) b = lim;
    return b;
  endfunction

  function automatic void clear_ring();
    head_off  = '0;
    tail_off  = '0;
    wrap_off  = q_bytes;
    fill_off  = '0;
    fill_open = 1'b0;
  endfunction

  // Header plus payload, padded to whole words
  function automatic logic [11:0] frame_bytes(input logic [7:0] sz);
    return (12'(sz) + 12'(HDR_BYTES) + 12'd3) & ~12'd3;
  endfunction

  // Addresses past the queue area read as zero
  function automatic logic [31:0] ram_word(input logic [11:0] addr);
    if (addr >= 12'(q_bytes) || (addr >> 2) >= MEM_WORDS) return '0;
    return ram_img[int'(addr >> 2)];
  endfunction

  function automatic void ram_store(input logic [11:0] addr, input logic [31:0] w);
    if ((addr >> 2) < MEM_WORDS) ram_img[int'(addr >> 2)] = w;
  endfunction

  // Advance the queue image by one request and form its response
  function automatic ring_resp_t predict_ring_response(input kind_t k,
                                                       input logic [31:0] d,
                                                       input logic fw,
                                                       input logic [7:0] wi);
    ring_resp_t  r;
    logic [11:0] flen;
    logic [11:0] start;
    logic [11:0] base;
    logic [31:0] hdr;
    r = '0;
    r.status = ST_OK;
    start = '0;
    if (k == KIND_PUSH && fw) begin
      flen = frame_bytes(d[23:16]);
      fill_open = 1'b0;
      if (d[23:16] == 8'd0) begin
        r.status = ST_ZERO_SIZE;
      end else if (head_off <= tail_off) begin
        if (12'(tail_off) + flen <= 12'(q_bytes)) begin
          start = 12'(tail_off);
          tail_off = OFFSET_W'(12'(tail_off) + flen);
        end else if (12'(head_off) > flen) begin
          wrap_off = tail_off;
          start = '0;
          tail_off = OFFSET_W'(flen);
        end else begin
          r.status = ST_FULL_WRAP;
        end
      end else if (12'(tail_off) + flen < 12'(head_off)) begin
        start = 12'(tail_off);
        tail_off = OFFSET_W'(12'(tail_off) + flen);
      end else begin
        r.status = ST_FULL_FRONT;
      end
      if (r.status == ST_OK) begin
        ram_store(start, d);
        fill_off = OFFSET_W'(start + 12'd4);
        fill_open = fill_off < tail_off;
        r.offset = start[9:0];
      end
    end else if (k == KIND_PUSH) begin
      // Fill the reserved space in order; drop surplus words
      if (fill_open && fill_off < tail_off) begin
        ram_store(12'(fill_off), d);
        fill_off = fill_off + OFFSET_W'(4);
        if (fill_off >= tail_off) fill_open = 1'b0;
      end else begin
        fill_open = 1'b0;
      end
    end else if (k == KIND_READ || k == KIND_SHIFT) begin
      if (head_off == tail_off) begin
        r.status = ST_EMPTY;
      end else begin
        base = (head_off >= wrap_off) ? 12'd0 : 12'(head_off);
        r.offset = base[9:0];
        if (k == KIND_READ) begin
          r.word = ram_word(base + (12'(wi) << 2));
        end else begin
          hdr = ram_word(base);
          flen = frame_bytes(hdr[23:16]);
          if (head_off >= wrap_off) begin
            head_off = OFFSET_W'(flen);
            wrap_off = q_bytes;
          end else begin
            head_off = OFFSET_W'(12'(head_off) + flen);
          end
        end
      end
    end
    r.empty = (head_off == tail_off);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    left_count = 0;
    foreach (ram_img[i]) ram_img[i] = '0;
    q_bytes = clamp_queue_bytes(QB_MAX);
    clear_ring();
  end

  // Compare retired responses, then track register writes and new requests
  always @(posedge clk) begin
    if (rst) begin
      q_bytes = clamp_queue_bytes(QB_MAX);
      clear_ring();
      expected_resps.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_resps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] response with no request outstanding: status %0d word %h",
                     $realtime, rsp.status, rsp.read_word);
        end else begin
          head_resp = expected_resps.pop_front();
          if (rsp.status !== head_resp.status || rsp.read_word !== head_resp.word ||
              rsp.is_empty !== head_resp.empty || rsp.frame_offset !== head_resp.offset) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"[%0t] response mismatch: status %0d/%0d word %h/%h ",
                        "empty %0d/%0d offset %0d/%0d (expected/actual)"},
                       $realtime, head_resp.status, rsp.status, head_resp.word,
                       rsp.read_word, head_resp.empty, rsp.is_empty,
                       head_resp.offset, rsp.frame_offset);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_QUEUE_BYTES) begin
        q_bytes = clamp_queue_bytes(pwdata);
        clear_ring();
      end
      if (req.valid && req.ready)
        expected_resps.push_back(predict_ring_response(kind_t'(req.kind), req.data_word,
                                                       req.first_word, req.word_index));
    end
    left_count = expected_resps.size();
  end

endmodule

FILE: sim/tb_variable_frame_ring_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_variable_frame_ring_queue: stimulus and verdict for the frame ring queue
// Fills the frame memory once, runs directed wrap, refusal and empty cases,
// then random frame traffic over several queue sizes with random idling on
// both channels and one long response stall.
// ---------------------------------------------------------------------------
module tb_variable_frame_ring_queue;
  import vfrq_pkg::*;

  localparam int MEM_WORDS   = 256;
  localparam int HDR_BYTES   = 12;
  localparam int PHASE_ITEMS = 34;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 500000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int sent_cnt    = 0;
  int recv_cnt    = 0;
  int cycle_cnt   = 0;
  int cfg_writes  = 0;
  int size_ceiling = 85;
  bit calm        = 1'b0;
  int fail_count;
  int left_count;

  vfrq_in_if  req_ch();
  vfrq_out_if rsp_ch();

  variable_frame_ring_queue #(
    .MEMORY_WORDS(MEM_WORDS),
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (req_ch),
    .res    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  vfrq_checker #(
    .MEM_WORDS(MEM_WORDS),
    .HDR_BYTES(HDR_BYTES)
  ) queue_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(fail_count),
    .left_count(left_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Count responses and enforce the cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && rsp_ch.valid && rsp_ch.ready) recv_cnt <= recv_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles: %0d requests sent, %0d responses",
               cycle_cnt, sent_cnt, recv_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int frame_fill_words(input int sz);
    return (sz + HDR_BYTES + 3) / 4 - 1;
  endfunction

  // Response side: random back-pressure plus one long hold-off
  initial begin : rsp_side
    int gap;
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && recv_cnt >= HOLD_AT) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          rsp_ch.ready <= 1'b0;
        end
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_req(input kind_t k, input logic [31:0] d, input logic fw,
                          input logic [7:0] wi);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= k;
    req_ch.data_word  <= d;
    req_ch.first_word <= fw;
    req_ch.word_index <= wi;
    do @(posedge clk); while (!req_ch.ready);
    sent_cnt++;
  endtask

  // Push a first word with the given size, then the fill words
  task automatic push_frame(input int sz, input int fills);
    logic [31:0] d;
    d = $urandom;
    d[23:16] = 8'(sz);
    send_req(KIND_PUSH, d, 1'b1, 8'($urandom));
    repeat (fills) send_req(KIND_PUSH, $urandom, 1'b0, 8'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (recv_cnt != sent_cnt) @(posedge clk);
  endtask

  // Write queue_bytes once the queue has gone quiet
  task automatic write_queue_bytes(input logic [OFFSET_W-1:0] v);
    logic [31:0] w;
    int est;
    w = $urandom;
    w[OFFSET_W-1:0] = v;
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_QUEUE_BYTES, 2'b00};
    pwdata  <= w;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
    // Shape frame sizes to the new queue size
    est = int'(v) & ~3;
    if (est < QB_MIN) est = QB_MIN;
    if (est > QB_MAX) est = QB_MAX;
    size_ceiling = est / 3;
    if (size_ceiling > 255) size_ceiling = 255;
  endtask

  // Frames with random content, reads, shifts and some noise
  task automatic run_random_phase(input int budget);
    int start_cnt;
    int r;
    int sz;
    int words;
    int fills;
    logic [31:0] d;
    start_cnt = sent_cnt;
    while (sent_cnt - start_cnt < budget) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                         : $urandom_range(1, size_ceiling);
        words = frame_fill_words(sz);
        fills = words;
        if ($urandom_range(0, 11) == 0) fills = $urandom_range(0, words);
        else if ($urandom_range(0, 19) == 0) fills = words + 1;
        push_frame(sz, fills);
      end else if (r < 64) begin
        send_req(KIND_READ, $urandom, 1'($urandom),
                 ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
      end else if (r < 93) begin
        send_req(KIND_SHIFT, $urandom, 1'($urandom), 8'($urandom));
      end else if (r < 95) begin
        send_req(KIND_NONE, $urandom, 1'($urandom), 8'($urandom));
      end else if (r < 98) begin
        d = $urandom;
        d[23:16] = 8'd0;
        send_req(KIND_PUSH, d, 1'b1, 8'($urandom));
      end else begin
        send_req(KIND_PUSH, $urandom, 1'b0, 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [OFFSET_W-1:0] qb_codes [6];
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_PUSH;
    req_ch.data_word  = '0;
    req_ch.first_word = 1'b0;
    req_ch.word_index = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    qb_codes = '{11'd2047, 11'd0, 11'd20, 11'd128, 11'd513, 11'($urandom_range(16, 1024))};

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Write every memory word with four 256-byte frames, then drop them
    calm = 1'b1;
    repeat (4) push_frame(244, frame_fill_words(244));
    repeat (4) send_req(KIND_SHIFT, $urandom, 1'b0, 8'($urandom));
    calm = 1'b0;

    // Empty queue, ignored kind, zero size and a stray fill word
    send_req(KIND_READ, 32'h0000_0000, 1'b0, 8'hFF);
    send_req(KIND_SHIFT, 32'hFFFF_FFFF, 1'b1, 8'h00);
    send_req(KIND_NONE, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_req(KIND_PUSH, 32'hFF00_FFFF, 1'b1, 8'h00);
    send_req(KIND_PUSH, 32'h0000_0000, 1'b0, 8'h00);
    // Largest frame wraps to offset zero, left partly filled
    send_req(KIND_PUSH, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_req(KIND_PUSH, 32'h0000_0000, 1'b0, 8'h00);
    send_req(KIND_PUSH, 32'hFFFF_FFFF, 1'b0, 8'h00);
    // Smallest frame, fully filled, plus one surplus word
    send_req(KIND_PUSH, 32'h0001_0000, 1'b1, 8'h00);
    send_req(KIND_PUSH, 32'hFFFF_FFFF, 1'b0, 8'h00);
    send_req(KIND_PUSH, 32'h0000_0000, 1'b0, 8'h00);
    send_req(KIND_PUSH, 32'hA5A5_5A5A, 1'b0, 8'h00);
    send_req(KIND_PUSH, 32'h1234_5678, 1'b0, 8'h00);
    send_req(KIND_READ, 32'h0, 1'b0, 8'h00);
    send_req(KIND_READ, 32'h0, 1'b0, 8'hFF);
    send_req(KIND_SHIFT, 32'h0, 1'b0, 8'h00);
    send_req(KIND_READ, 32'h0, 1'b0, 8'h03);
    send_req(KIND_SHIFT, 32'h0, 1'b0, 8'h00);

    // Small queue: wrap at the back, then refuse ahead of the front
    write_queue_bytes(11'd67);
    repeat (3) push_frame(1, 0);
    send_req(KIND_SHIFT, 32'h0, 1'b0, 8'h00);
    push_frame(1, 0);
    send_req(KIND_SHIFT, 32'h0, 1'b0, 8'h00);
    push_frame(1, 0);
    push_frame(1, 0);
    send_req(KIND_READ, 32'h0, 1'b0, 8'h00);
    send_req(KIND_SHIFT, 32'h0, 1'b0, 8'h00);
    send_req(KIND_SHIFT, 32'h0, 1'b0, 8'h00);

    // Random traffic over a range of queue sizes, one phase without idling
    foreach (qb_codes[i]) begin
      write_queue_bytes(qb_codes[i]);
      calm = (i == 2);
      run_random_phase(PHASE_ITEMS);
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d responses over %0d queue size settings,",
             sent_cnt, recv_cnt, cfg_writes + 1);
    $display("with wrapped frames, refusals, empty accesses and a %0d-cycle response stall",
             HOLD_CYCLES);
    if (fail_count == 0 && left_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: variable_frame_ring_queue.f
design/vfrq_pkg.sv
design/vfrq_if.sv
design/vfrq_ram.sv
design/vfrq_cfg.sv
design/variable_frame_ring_queue.sv
sim/vfrq_checker.sv
sim/tb_variable_frame_ring_queue.sv
